// ===== rtl/crchk_pkg.sv =====
// crchk_pkg: types and constants shared by the counter reply checker
// no dependencies; used by every rtl file of the block

package crchk_pkg;

    localparam int unsigned BYTE_W    = 8;
    localparam int unsigned SUM_W     = 10;
    localparam int unsigned GROUP_CNT = 4;

    localparam logic [BYTE_W-1:0] ACK_MARK     = 8'h55;
    localparam logic [BYTE_W-1:0] FAULT_MARK   = 8'h01;
    localparam logic [BYTE_W-1:0] KIND_COUNT   = 8'h02;
    localparam logic [BYTE_W-1:0] KIND_CLEAR_A = 8'h03;
    localparam logic [BYTE_W-1:0] KIND_CLEAR_B = 8'h04;
    localparam logic [BYTE_W-1:0] ZERO_BYTE    = 8'h00;

    typedef logic [GROUP_CNT-1:0][SUM_W-1:0] t_group_sums;

    // reply state after the current byte has been taken in
    typedef struct packed {
        logic [BYTE_W-1:0] running_sum;
        logic [BYTE_W-1:0] last_nonzero;
        logic              fault_seen;
        logic              ack_seen;
        t_group_sums       group_sums;
    } t_snap;

endpackage

// ===== rtl/crchk_ifs.sv =====
// crchk_in_if / crchk_out_if: valid/ready channels of the counter reply checker
// depends on crchk_pkg for field widths

interface crchk_in_if;
    logic                              valid;
    logic                              ready;
    logic [crchk_pkg::BYTE_W-1:0]      data_byte;
    logic                              last_byte;
    logic [crchk_pkg::BYTE_W-1:0]      reply_kind;

    modport source (output valid, data_byte, last_byte, reply_kind, input ready);
    modport sink   (input valid, data_byte, last_byte, reply_kind, output ready);
endinterface

interface crchk_out_if;
    logic                              valid;
    logic                              ready;
    logic                              reply_valid;
    logic [crchk_pkg::SUM_W-1:0]       current_in;
    logic [crchk_pkg::SUM_W-1:0]       current_out;
    logic [crchk_pkg::SUM_W-1:0]       overall_in;
    logic [crchk_pkg::SUM_W-1:0]       overall_out;

    modport source (output valid, reply_valid, current_in, current_out, overall_in,
                    overall_out, input ready);
    modport sink   (input valid, reply_valid, current_in, current_out, overall_in,
                    overall_out, output ready);
endinterface

// ===== rtl/crchk_accum.sv =====
// crchk_accum: per-reply state registers and byte update logic
// depends on crchk_pkg; feeds crchk_judge through a t_snap struct

module crchk_accum #(
    parameter int unsigned MAX_REPLY_LEN = 255
) (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_take,
    input  logic [crchk_pkg::BYTE_W-1:0] i_data_byte,
    input  logic                         i_last_byte,
    output crchk_pkg::t_snap             o_snap
);
    import crchk_pkg::*;

    localparam int unsigned POS_W = $clog2(MAX_REPLY_LEN + 1);
    localparam logic [POS_W-1:0] POS_MAX = POS_W'(MAX_REPLY_LEN);

    logic [POS_W-1:0] r_pos;
    logic [POS_W-1:0] n_pos;
    t_snap            r_state;
    t_snap            n_state;
    logic [POS_W-1:0] grp_off;
    logic [1:0]       grp_idx;
    logic             in_window;

    assign grp_off   = r_pos - POS_W'(4);
    assign grp_idx   = grp_off[3:2];
    assign in_window = (r_pos >= POS_W'(4)) && (r_pos <= POS_W'(19));

    always_comb begin
        n_state = r_state;
        n_pos   = r_pos;
        if (r_pos < POS_MAX) begin
            n_state.running_sum = r_state.running_sum + i_data_byte;
            if (i_data_byte != ZERO_BYTE) begin
                n_state.last_nonzero = i_data_byte;
            end
            if (r_pos == POS_W'(3) && i_data_byte == ACK_MARK) begin
                n_state.ack_seen = 1'b1;
            end
            if ((r_pos == POS_W'(4) || r_pos == POS_W'(8) || r_pos == POS_W'(12) ||
                 r_pos == POS_W'(16)) && i_data_byte == FAULT_MARK) begin
                n_state.fault_seen = 1'b1;
            end
            if (in_window) begin
                n_state.group_sums[grp_idx] = r_state.group_sums[grp_idx] +
                                              SUM_W'(i_data_byte);
            end
            n_pos = r_pos + POS_W'(1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pos   <= '0;
            r_state <= '0;
        end else if (i_take) begin
            if (i_last_byte) begin
                r_pos   <= '0;
                r_state <= '0;
            end else begin
                r_pos   <= n_pos;
                r_state <= n_state;
            end
        end
    end

    assign o_snap = n_state;

endmodule

// ===== rtl/crchk_judge.sv =====
// crchk_judge: checksum match and request-kind checks for a finished reply
// depends on crchk_pkg; combinational, driven by crchk_accum

module crchk_judge (
    input  crchk_pkg::t_snap             i_snap,
    input  logic [crchk_pkg::BYTE_W-1:0] i_reply_kind,
    output logic                         o_reply_valid
);
    import crchk_pkg::*;

    logic [BYTE_W-1:0] rest;
    logic              sum_ok;

    assign rest   = i_snap.running_sum - i_snap.last_nonzero;
    assign sum_ok = (rest == i_snap.last_nonzero) && (rest != ZERO_BYTE);

    always_comb begin
        o_reply_valid = sum_ok;
        case (i_reply_kind) inside
            KIND_COUNT: begin
                if (i_snap.fault_seen) begin
                    o_reply_valid = 1'b0;
                end
            end
            KIND_CLEAR_A, KIND_CLEAR_B: begin
                if (!i_snap.ack_seen) begin
                    o_reply_valid = 1'b0;
                end
            end
            default: begin
                o_reply_valid = sum_ok;
            end
        endcase
    end

endmodule

// ===== rtl/counter_reply_checker.sv =====
// counter_reply_checker: top level, byte-wise checker of people-counter replies
// depends on crchk_pkg, crchk_ifs, crchk_accum and crchk_judge
//
// i_req carries one reply byte per request with a last-byte mark and the kind
// of the request that the reply answers (the kind is looked at on the last
// byte only). o_rsp gives one result per reply: the checksum/kind verdict and
// the plain sums of bytes 4-7, 8-11, 12-15 and 16-19.
// A byte is taken each cycle that i_req.ready is high; the result shows on
// o_rsp in the cycle after the last byte is accepted and is held in an
// output register until taken. i_req.ready is low only while a result waits
// and o_rsp.ready is low; bytes resume in the cycle that result is taken.
// Bytes past MAX_REPLY_LEN are ignored but the last-byte mark still closes
// the reply. State returns to zero after each reply.
// Reset clears the reply state and the output register at once; the block
// accepts bytes in the first cycle after reset.

module counter_reply_checker #(
    parameter int unsigned MAX_REPLY_LEN = 255
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    crchk_in_if.sink    i_req,
    crchk_out_if.source o_rsp
);
    import crchk_pkg::*;

    t_snap              snap;
    logic               take;
    logic               judge_valid;
    logic               r_out_valid;
    logic               r_reply_valid;
    t_group_sums        r_sums;

    assign i_req.ready = !r_out_valid || o_rsp.ready;
    assign take        = i_req.valid && i_req.ready;

    crchk_accum #(
        .MAX_REPLY_LEN(MAX_REPLY_LEN)
    ) u_accum (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_take      (take),
        .i_data_byte (i_req.data_byte),
        .i_last_byte (i_req.last_byte),
        .o_snap      (snap)
    );

    crchk_judge u_judge (
        .i_snap        (snap),
        .i_reply_kind  (i_req.reply_kind),
        .o_reply_valid (judge_valid)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (take && i_req.last_byte) begin
            r_out_valid <= 1'b1;
        end else if (o_rsp.ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_reply_valid <= 1'b0;
            r_sums        <= '0;
        end else if (take && i_req.last_byte) begin
            r_reply_valid <= judge_valid;
            r_sums        <= snap.group_sums;
        end
    end

    assign o_rsp.valid       = r_out_valid;
    assign o_rsp.reply_valid = r_reply_valid;
    assign o_rsp.current_in  = r_sums[0];
    assign o_rsp.current_out = r_sums[1];
    assign o_rsp.overall_in  = r_sums[2];
    assign o_rsp.overall_out = r_sums[3];

endmodule

// ===== rtl/crchk_checker.sv =====
// crchk_checker: port-level assertions for counter_reply_checker
// depends on crchk_pkg; attached to the top level by the bind below

module crchk_checker (
    input logic                         clk,
    input logic                         rst_n,
    input logic                         in_valid,
    input logic                         in_ready,
    input logic                         in_last,
    input logic                         out_valid,
    input logic                         out_ready,
    input logic                         out_reply_valid,
    input logic [crchk_pkg::SUM_W-1:0]  out_current_in
);
    import crchk_pkg::*;

    // stalled result stays up
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid)
        else $error("result dropped while stalled");

    // last byte gives a result next cycle
    a_last_gives_rsp: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && in_ready && in_last |=> out_valid)
        else $error("no result after last byte");

    // a new result only after a last byte
    a_no_invented: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid) |-> $past(in_valid && in_ready && in_last))
        else $error("result without last byte");

    // input is never blocked while the output slot is free
    a_ready_free: assert property (@(posedge clk) disable iff (!rst_n)
        !out_valid |-> in_ready)
        else $error("request stalled with empty output");

    // held verdict and current_in of a stalled result do not change
    a_payload_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> $stable(out_reply_valid) && $stable(out_current_in))
        else $error("stalled result changed");

endmodule

bind counter_reply_checker crchk_checker u_crchk_checker (
    .clk             (i_clk),
    .rst_n           (i_rst_n),
    .in_valid        (i_req.valid),
    .in_ready        (i_req.ready),
    .in_last         (i_req.last_byte),
    .out_valid       (o_rsp.valid),
    .out_ready       (o_rsp.ready),
    .out_reply_valid (o_rsp.reply_valid),
    .out_current_in  (o_rsp.current_in)
);
